/* rtl/aapf_pkg.sv */
// Shared types and constants for the accelerometer activity, posture and fall block.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package aapf_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 4;

  // Classifier constants: x thresholds and Q2.16 slope coefficients
  localparam logic signed [15:0] REST_X_LIMIT = 16'sd4918;
  localparam logic signed [15:0] UP_X_LIMIT   = -16'sd5740;
  localparam logic signed [33:0] COEF_K1      = 34'sd91750;
  localparam logic signed [33:0] COEF_K2      = -34'sd46811;

  localparam logic [31:0] STAY_LOW_RST  = 32'd0;
  localparam logic [31:0] STAY_HIGH_RST = 32'd3221225472;
  localparam logic [31:0] FALL_LOW_RST  = 32'd0;
  localparam logic [31:0] FALL_HIGH_RST = 32'd3221225472;

  typedef enum logic [2:0] {
    POSTURE_VERTICAL = 3'd0,
    POSTURE_BACK     = 3'd1,
    POSTURE_LEFT     = 3'd2,
    POSTURE_STOMACH  = 3'd3,
    POSTURE_RIGHT    = 3'd4,
    POSTURE_ACTIVE   = 3'd5
  } posture_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STAY_LOW  = 4'd0,
    CFG_STAY_HIGH = 4'd1,
    CFG_FALL_LOW  = 4'd2,
    CFG_FALL_HIGH = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               posture_request;
  } in_t;

  typedef struct packed {
    logic [31:0] magnitude_sq;
    logic        is_active;
    logic [2:0]  posture_code;
    logic        fall_low_seen;
    logic        fall_high_seen;
  } out_t;

  // One classified beat between front and back
  typedef struct packed {
    logic [31:0] magnitude_sq;
    posture_e    cls;
    logic        posture_request;
  } item_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
  } cfg_wr_t;

endpackage

`default_nettype wire

/* rtl/aapf_front.sv */
// Front end: accepts raw samples, squares the axes and forms the slope products,
// then sums the magnitude and classifies posture. Depends on aapf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aapf_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire aapf_pkg::in_t  in_data_i,
  output logic                push_valid_o,
  input  wire logic           push_ready_i,
  output aapf_pkg::item_t     push_data_o
);
  import aapf_pkg::*;

  // Stage A: products
  logic               a_valid_q;
  logic [30:0]        a_sqx_q, a_sqy_q, a_sqz_q;
  logic signed [33:0] a_p1_q, a_p2_q;
  logic signed [15:0] a_x_q, a_y_q;
  logic               a_req_q;

  // Stage B: classified beat
  logic  b_valid_q;
  item_t b_item_q;

  logic a_adv, b_adv;
  logic signed [31:0] sq_x, sq_y, sq_z;
  logic signed [33:0] p1, p2;

  logic signed [15:0] t1, t2;
  logic [31:0]        mag;
  posture_e           cls;

  function automatic logic signed [15:0] trunc_sat(input logic signed [33:0] p);
    logic signed [33:0] adj;
    logic signed [17:0] q;
    logic signed [15:0] r;
    // toward zero: bias negative products before the shift
    adj = p[33] ? (p + 34'sd65535) : p;
    q   = adj[33:16];
    if (q > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (q < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  function automatic posture_e classify(input logic signed [15:0] x,
                                        input logic signed [15:0] y,
                                        input logic signed [15:0] z,
                                        input logic signed [15:0] lim1,
                                        input logic signed [15:0] lim2);
    posture_e r;
    if (x > 16'sd0) begin
      if (x > REST_X_LIMIT) begin
        r = POSTURE_VERTICAL;
      end else if (y < 16'sd0) begin
        r = (z < 16'sd0) ? POSTURE_BACK : POSTURE_LEFT;
      end else begin
        r = (z > 16'sd0) ? POSTURE_STOMACH : POSTURE_RIGHT;
      end
    end else begin
      if (x < UP_X_LIMIT) begin
        r = POSTURE_VERTICAL;
      end else if (y > lim1) begin
        r = (y < lim2) ? POSTURE_BACK : POSTURE_LEFT;
      end else begin
        r = (y > lim2) ? POSTURE_STOMACH : POSTURE_RIGHT;
      end
    end
    return r;
  endfunction

  logic signed [15:0] a_z_q;

  assign b_adv      = !b_valid_q || push_ready_i;
  assign a_adv      = !a_valid_q || b_adv;
  assign in_stall_o = !a_adv;

  always_comb begin
    sq_x = 32'(in_data_i.accel_x) * 32'(in_data_i.accel_x);
    sq_y = 32'(in_data_i.accel_y) * 32'(in_data_i.accel_y);
    sq_z = 32'(in_data_i.accel_z) * 32'(in_data_i.accel_z);
    p1   = 34'(in_data_i.accel_z) * COEF_K1;
    p2   = 34'(in_data_i.accel_z) * COEF_K2;
  end

  always_comb begin
    mag = 32'(a_sqx_q) + 32'(a_sqy_q) + 32'(a_sqz_q);
    t1  = trunc_sat(a_p1_q);
    t2  = trunc_sat(a_p2_q);
    cls = classify(a_x_q, a_y_q, a_z_q, t1, t2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_q <= in_valid_i;
      end
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && in_valid_i) begin
      a_sqx_q <= sq_x[30:0];
      a_sqy_q <= sq_y[30:0];
      a_sqz_q <= sq_z[30:0];
      a_p1_q  <= p1;
      a_p2_q  <= p2;
      a_x_q   <= in_data_i.accel_x;
      a_y_q   <= in_data_i.accel_y;
      a_z_q   <= in_data_i.accel_z;
      a_req_q <= in_data_i.posture_request;
    end
    if (b_adv && a_valid_q) begin
      b_item_q.magnitude_sq    <= mag;
      b_item_q.cls             <= cls;
      b_item_q.posture_request <= a_req_q;
    end
  end

  assign push_valid_o = b_valid_q;
  assign push_data_o  = b_item_q;

endmodule

`default_nettype wire

/* rtl/aapf_queue.sv */
// Short FIFO of classified beats between the front end and the back end.
// Depends on aapf_pkg for the beat type.
`timescale 1ns / 1ps
`default_nettype none

module aapf_queue #(
  parameter int unsigned Depth = aapf_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire aapf_pkg::item_t push_data_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output aapf_pkg::item_t      pop_data_o
);
  import aapf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/aapf_back.sv */
// Back end: limit registers, still window test, posture and fall latch state,
// and the output register. Depends on aapf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aapf_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire aapf_pkg::cfg_wr_t cfg_wr_i,
  input  wire logic              pop_valid_i,
  output logic                   pop_ready_o,
  input  wire aapf_pkg::item_t   pop_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output aapf_pkg::out_t         out_data_o
);
  import aapf_pkg::*;

  logic [31:0] stay_low_q, stay_high_q, fall_low_q, fall_high_q;
  posture_e    posture_q, posture_d;
  logic        low_q, low_d, high_q, high_d;
  logic        out_valid_q;
  out_t        out_q;
  logic        still, take;
  logic [31:0] mag;

  assign pop_ready_o = !out_valid_q || !out_stall_i;
  assign take        = pop_valid_i && pop_ready_o;
  assign mag         = pop_data_i.magnitude_sq;
  assign still       = (mag >= stay_low_q) && (mag <= stay_high_q);

  always_comb begin
    if (!still) begin
      posture_d = POSTURE_ACTIVE;
    end else if (pop_data_i.posture_request) begin
      posture_d = pop_data_i.cls;
    end else begin
      posture_d = posture_q;
    end
    low_d  = low_q;
    high_d = high_q;
    // low test comes first; a set low latch may then see the impact in the same beat
    if ((mag < fall_low_q) && !low_q) begin
      low_d  = 1'b1;
      high_d = 1'b0;
    end
    if (low_d && (mag > fall_high_q)) begin
      high_d = 1'b1;
      low_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stay_low_q  <= STAY_LOW_RST;
      stay_high_q <= STAY_HIGH_RST;
      fall_low_q  <= FALL_LOW_RST;
      fall_high_q <= FALL_HIGH_RST;
    end else if (cfg_wr_i.en) begin
      unique case (cfg_wr_i.idx)
        CFG_STAY_LOW:  stay_low_q  <= cfg_wr_i.data;
        CFG_STAY_HIGH: stay_high_q <= cfg_wr_i.data;
        CFG_FALL_LOW:  fall_low_q  <= cfg_wr_i.data;
        CFG_FALL_HIGH: fall_high_q <= cfg_wr_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posture_q   <= POSTURE_ACTIVE;
      low_q       <= 1'b0;
      high_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        posture_q <= posture_d;
        low_q     <= low_d;
        high_q    <= high_d;
      end
      if (pop_ready_o) begin
        out_valid_q <= pop_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.magnitude_sq   <= mag;
      out_q.is_active      <= !still;
      out_q.posture_code   <= posture_d;
      out_q.fall_low_seen  <= low_d;
      out_q.fall_high_seen <= high_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/accel_activity_posture_fall.sv */
// Accelerometer activity, posture and fall latch block: top level.
// Instantiates aapf_front, aapf_queue and aapf_back; depends on aapf_pkg.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one raw x, y, z sample
// plus a posture request per beat, taken when valid is high and stall is low.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per
// sample, in order: squared magnitude, activity flag, posture code and the
// two fall latches as they stand after that sample.
// Configuration channel (cfg_valid_i / cfg_ready_o): index 0 stay low limit,
// 1 stay high limit, 2 fall low limit, 3 fall high limit; other indexes are
// dropped. Ready is always high. Write only while the block is idle.
// Throughput is one sample per cycle while the receiver does not stall. A
// taken sample passes the product register, the register for the magnitude
// sum and posture tree on the registered products, the queue and the output
// register, where the limits and latches are applied.
// While the receiver stalls, the output register holds and the queue and the
// front pipeline fill; in_stall_o rises once all of them are full.
// Reset empties the pipeline, loads the limit reset values, sets the posture
// to in activity and clears both fall latches.
`timescale 1ns / 1ps
`default_nettype none

module accel_activity_posture_fall #(
  parameter int unsigned QueueDepth = aapf_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire aapf_pkg::in_t                  in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output aapf_pkg::out_t                      out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [aapf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i
);
  import aapf_pkg::*;

  logic    push_valid, push_ready, pop_valid, pop_ready;
  item_t   push_data, pop_data;
  cfg_wr_t cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = '{en: cfg_valid_i && cfg_ready_o, idx: cfg_index_i, data: cfg_data_i};

  aapf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  aapf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  aapf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // An active sample always reports the in-activity posture
  a_active_posture : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_active) |-> (out_data_o.posture_code == POSTURE_ACTIVE))
    else $error("active result without in-activity posture");

  // Each latch clears the other when it sets
  a_latch_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.fall_low_seen && out_data_o.fall_high_seen))
    else $error("both fall latches set");

  a_mag_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.magnitude_sq <= 32'd3221225472))
    else $error("magnitude out of range");

  // The front may only hold off the sender while it has work in flight
  a_stall_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (push_valid && !push_ready))
    else $error("input stalled with room downstream");

endmodule

`default_nettype wire
